// ----- rtl/strided_1d_convolution_padded_core_assert.svh -----
// assertion macros for the checker module cnv_check
`ifndef STRIDED_1D_CONVOLUTION_PADDED_CORE_ASSERT_SVH
`define STRIDED_1D_CONVOLUTION_PADDED_CORE_ASSERT_SVH

// condition in the same cycle
`define CNV_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition in the following cycle
`define CNV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// condition in the cycle after reset, reset itself not masked
`define CNV_ASSERT_RESET(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/cnv_pkg.sv -----
// shared types, codes and constants of the strided convolution core
package cnv_pkg;

  localparam int MAX_TAPS_DEF    = 64;
  localparam int MAX_SAMPLES_DEF = 1024;

  // input word kinds
  localparam logic [1:0] ACT_LOAD_TAP    = 2'd0;
  localparam logic [1:0] ACT_LOAD_SAMPLE = 2'd1;
  localparam logic [1:0] ACT_COMPUTE     = 2'd2;

  // register indexes
  localparam logic [2:0] REG_INPUT_LENGTH   = 3'd0;
  localparam logic [2:0] REG_KERNEL_LENGTH  = 3'd1;
  localparam logic [2:0] REG_KERNEL_ORIGIN  = 3'd2;
  localparam logic [2:0] REG_START_POSITION = 3'd3;
  localparam logic [2:0] REG_STEP           = 3'd4;
  localparam logic [2:0] REG_PAD_MODE       = 3'd5;
  localparam logic [2:0] REG_PRE_WEIGHT     = 3'd6;

  // pad modes
  localparam logic [1:0] PAD_FILL   = 2'd0;
  localparam logic [1:0] PAD_CLAMP  = 2'd1;
  localparam logic [1:0] PAD_CYCLIC = 2'd2;
  localparam logic [1:0] PAD_MIRROR = 2'd3;

  // position width and fold divisor width
  localparam int POS_W  = 22;
  localparam int FOLD_W = 12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_FSTART,
    ST_FOLD,
    ST_MAC,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic tap_we;
    logic smp_we;
  } store_we_t;

endpackage

// ----- rtl/strided_1d_convolution_padded_core.sv -----
// In-range load words go into the memories on acceptance; a compute word steps through setup,
// fold start, the position fold, the tap steps and drain; finish registers its result word.
// One word at a time: a compute word holds the input until finish loads its result, set by
// the single tap multiply-accumulate fed from the tap and sample memories.
// Reset: synchronous, active high; control and config registers take their reset values;
// datapath registers and memories are not reset, memories hold undefined data until loaded.
module strided_1d_convolution_padded_core #(
  parameter int MAX_TAPS    = cnv_pkg::MAX_TAPS_DEF,
  parameter int MAX_SAMPLES = cnv_pkg::MAX_SAMPLES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // index[11:0], sample_value[27:12], prior_output[59:28]
  input  logic [1:0]  s_tuser,   // action[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // output_index[11:0], result[43:12]
  output logic        m_tuser,   // saturated[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import cnv_pkg::*;

  localparam int TAW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int SAW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

  // configuration registers
  logic [10:0]        input_length;
  logic [6:0]         kernel_length;
  logic [5:0]         kernel_origin;
  logic signed [12:0] start_position;
  logic [6:0]         step;
  logic [1:0]         pad_mode;
  logic signed [15:0] pre_weight;

  // working registers
  state_t             state, state_next;
  logic [11:0]        idx_r;
  logic signed [31:0] prior_r;
  logic signed [47:0] wprod;
  logic signed [POS_W-1:0] praw;
  logic [FOLD_W-1:0]  wm;
  logic [6:0]         t;
  logic [1:0]         dcnt;
  logic               v1, v2;
  logic signed [31:0] mprod;
  logic signed [37:0] acc;

  // derived values
  logic [10:0]        n_eff;
  logic [6:0]         k_eff;
  logic [5:0]         org_eff;
  logic [FOLD_W-1:0]  per;
  logic [FOLD_W-1:0]  div;
  logic [18:0]        istep;
  logic signed [POS_W-1:0] p0;
  logic signed [POS_W-1:0] n_s;
  logic signed [POS_W-1:0] wpos;
  logic               contrib;
  logic               fold_start, fold_done;
  logic [FOLD_W-1:0]  fold_rem;
  logic               in_acc, mac_issue, out_load;
  logic signed [34:0] total;
  logic               sat;
  logic signed [31:0] res;
  store_we_t          we;
  logic signed [15:0] tap_q, smp_q;

  assign cfg_ready = 1'b1;
  assign in_acc    = s_tvalid && s_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      input_length   <= 11'd1;
      kernel_length  <= 7'd1;
      kernel_origin  <= '0;
      start_position <= '0;
      step           <= 7'd1;
      pad_mode       <= PAD_FILL;
      pre_weight     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_INPUT_LENGTH:   input_length   <= cfg_data[10:0];
        REG_KERNEL_LENGTH:  kernel_length  <= cfg_data[6:0];
        REG_KERNEL_ORIGIN:  kernel_origin  <= cfg_data[5:0];
        REG_START_POSITION: start_position <= cfg_data[12:0];
        REG_STEP:           step           <= cfg_data[6:0];
        REG_PAD_MODE:       pad_mode       <= cfg_data[1:0];
        REG_PRE_WEIGHT:     pre_weight     <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective lengths, fold divisor and first sample position
  always_comb begin
    if (input_length == '0) n_eff = 11'd1;
    else if (int'(input_length) > MAX_SAMPLES) n_eff = 11'(MAX_SAMPLES);
    else n_eff = input_length;
    if (kernel_length == '0) k_eff = 7'd1;
    else if (int'(kernel_length) > MAX_TAPS) k_eff = 7'(MAX_TAPS);
    else k_eff = kernel_length;
    org_eff = ({1'b0, kernel_origin} > k_eff - 7'd1) ? 6'(k_eff - 7'd1) : kernel_origin;
    per     = FOLD_W'({n_eff - 11'd1, 1'b0});
    if (pad_mode == PAD_CYCLIC) div = FOLD_W'(n_eff);
    else if (n_eff == 11'd1) div = FOLD_W'(1);
    else div = per;
    istep = 19'({7'b0, idx_r} * {12'b0, step});
    p0    = POS_W'(start_position) + POS_W'(istep) + POS_W'(org_eff);
    n_s   = POS_W'(n_eff);
  end

  // sample position for the current tap under the pad mode
  always_comb begin
    contrib = 1'b1;
    wpos    = praw;
    case (pad_mode)
      PAD_FILL: begin
        contrib = (praw >= 0) && (praw < n_s);
      end
      PAD_CLAMP: begin
        if (praw < 0) wpos = '0;
        else if (praw >= n_s) wpos = n_s - POS_W'(1);
      end
      PAD_CYCLIC: begin
        wpos = POS_W'(wm);
      end
      PAD_MIRROR: begin
        if (n_eff == 11'd1) wpos = '0;
        else if (wm >= FOLD_W'(n_eff)) wpos = POS_W'(per - wm);
        else wpos = POS_W'(wm);
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_acc && s_tuser == ACT_COMPUTE) state_next = ST_SETUP;
      ST_SETUP:  state_next = ST_FSTART;
      ST_FSTART: state_next = ST_FOLD;
      ST_FOLD:   if (fold_done) state_next = ST_MAC;
      ST_MAC:    if (t == k_eff - 7'd1) state_next = ST_DRAIN;
      ST_DRAIN:  if (dcnt == 2'd1) state_next = ST_FINISH;
      ST_FINISH: if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_tready   = (state == ST_IDLE);
    fold_start = (state == ST_FSTART);
    mac_issue  = (state == ST_MAC);
    out_load   = (state == ST_FINISH) && (!m_tvalid || m_tready);
  end

  // load writes into the stores
  always_comb begin
    we.tap_we = in_acc && (s_tuser == ACT_LOAD_TAP) && (int'(s_tdata[11:0]) < MAX_TAPS);
    we.smp_we = in_acc && (s_tuser == ACT_LOAD_SAMPLE) &&
                (int'(s_tdata[11:0]) < MAX_SAMPLES);
  end

  cnv_store #(
    .MAX_TAPS    (MAX_TAPS),
    .MAX_SAMPLES (MAX_SAMPLES),
    .TAW         (TAW),
    .SAW         (SAW)
  ) u_store (
    .clk       (clk),
    .we        (we),
    .tap_waddr (TAW'(s_tdata[11:0])),
    .smp_waddr (SAW'(s_tdata[11:0])),
    .wdata     (s_tdata[27:12]),
    .tap_raddr (TAW'(t)),
    .smp_raddr (SAW'(wpos)),
    .tap_q     (tap_q),
    .smp_q     (smp_q)
  );

  cnv_fold u_fold (
    .clk   (clk),
    .rst   (rst),
    .start (fold_start),
    .x     (praw),
    .d     (div),
    .done  (fold_done),
    .rem   (fold_rem)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      v1    <= 1'b0;
      v2    <= 1'b0;
      t     <= '0;
      dcnt  <= '0;
    end else begin
      state <= state_next;
      v1    <= mac_issue && contrib;
      v2    <= v1;
      if (state == ST_SETUP) t <= '0;
      else if (mac_issue) t <= t + 7'd1;
      if (state == ST_DRAIN) dcnt <= dcnt + 2'd1;
      else dcnt <= '0;
    end
  end

  // datapath: capture, position walk, multiply-accumulate
  always_ff @(posedge clk) begin
    if (in_acc) begin
      idx_r   <= s_tdata[11:0];
      prior_r <= s_tdata[59:28];
    end
    if (state == ST_SETUP) begin
      praw  <= p0;
      wprod <= prior_r * pre_weight;
      acc   <= '0;
    end else begin
      if (mac_issue) praw <= praw - POS_W'(1);
      if (v2) acc <= acc + 38'(mprod);
    end
    if (fold_done) wm <= fold_rem;
    else if (mac_issue) wm <= (wm == '0) ? div - FOLD_W'(1) : wm - FOLD_W'(1);
    mprod <= tap_q * smp_q;
  end

  // scaling and saturation
  always_comb begin
    total = 35'(wprod >>> 14) + 35'(acc >>> 15);
    sat   = (total[34:31] != {4{total[31]}});
    if (!sat) res = total[31:0];
    else if (total[34]) res = 32'sh8000_0000;
    else res = 32'sh7fff_ffff;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (out_load) begin
      m_tdata <= {4'b0, res, idx_r};
      m_tuser <= sat;
    end
  end

endmodule

// ----- rtl/cnv_fold.sv -----
// iterative remainder unit: folds a signed position into 0..divisor-1
module cnv_fold (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [cnv_pkg::POS_W-1:0]    x,
  input  logic        [cnv_pkg::FOLD_W-1:0]   d,
  output logic                                done,
  output logic        [cnv_pkg::FOLD_W-1:0]   rem
);
  import cnv_pkg::*;

  localparam int MAG_W = POS_W - 1;
  localparam logic [4:0] LAST = 5'(MAG_W - 1);

  logic [MAG_W-1:0]  mag;
  logic              neg;
  logic              busy;
  logic              fix;
  logic [4:0]        cnt;
  logic [FOLD_W-1:0] shifted;
  logic [FOLD_W-1:0] rem_next;
  logic [POS_W-1:0]  negx;

  // magnitude of the start value
  assign negx = POS_W'(-x);

  // one remainder bit per cycle
  always_comb begin
    shifted  = {rem[FOLD_W-2:0], mag[MAG_W-1]};
    rem_next = (shifted >= d) ? shifted - d : shifted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        mag  <= x[POS_W-1] ? negx[MAG_W-1:0] : x[MAG_W-1:0];
        neg  <= x[POS_W-1];
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= rem_next;
        mag <= {mag[MAG_W-2:0], 1'b0};
        cnt <= cnt + 5'd1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          fix  <= 1'b1;
        end
      end else if (fix) begin
        // negative input: reflect the remainder into the positive range
        if (neg && (rem != '0)) rem <= d - rem;
        fix  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// ----- rtl/cnv_store.sv -----
// tap and sample memories, one write and one registered read each per cycle
module cnv_store #(
  parameter int MAX_TAPS    = cnv_pkg::MAX_TAPS_DEF,
  parameter int MAX_SAMPLES = cnv_pkg::MAX_SAMPLES_DEF,
  parameter int TAW         = 6,
  parameter int SAW         = 10
) (
  input  logic                clk,
  input  cnv_pkg::store_we_t  we,
  input  logic [TAW-1:0]      tap_waddr,
  input  logic [SAW-1:0]      smp_waddr,
  input  logic signed [15:0]  wdata,
  input  logic [TAW-1:0]      tap_raddr,
  input  logic [SAW-1:0]      smp_raddr,
  output logic signed [15:0]  tap_q,
  output logic signed [15:0]  smp_q
);
  import cnv_pkg::*;

  logic signed [15:0] tap_mem [MAX_TAPS];
  logic signed [15:0] smp_mem [MAX_SAMPLES];

  // tap memory
  always_ff @(posedge clk) begin
    if (we.tap_we) tap_mem[tap_waddr] <= wdata;
    tap_q <= tap_mem[tap_raddr];
  end

  // sample memory
  always_ff @(posedge clk) begin
    if (we.smp_we) smp_mem[smp_waddr] <= wdata;
    smp_q <= smp_mem[smp_raddr];
  end

endmodule

// ----- rtl/cnv_check.sv -----
// port-level checks on the result channel of the convolution core
`include "strided_1d_convolution_padded_core_assert.svh"

module cnv_check (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tuser
);

  // stalled word stays offered
  `CNV_ASSERT_NEXT(a_hold_valid, clk, rst, m_tvalid && !m_tready, m_tvalid, "valid dropped")

  // stalled word keeps its data
  `CNV_ASSERT_NEXT(a_hold_data, clk, rst, m_tvalid && !m_tready, $stable(m_tdata), "data moved")

  // clipping flag only with a limit value
  `CNV_ASSERT_NOW(a_sat_limit, clk, rst, m_tvalid && m_tuser, (m_tdata[43:12] == 32'h7fff_ffff) || (m_tdata[43:12] == 32'h8000_0000), "bad clip")

  // no word straight after reset
  `CNV_ASSERT_RESET(a_reset_idle, clk, rst, !m_tvalid, "valid after reset")

endmodule

bind strided_1d_convolution_padded_core cnv_check u_cnv_check (.*);
